// ===== sv/umpq_pkg.sv =====
// Shared types and codes for the unordered max priority queue.
// Depends on nothing; every other file uses it by scoped names.
package umpq_pkg;

  localparam int DataW = 32;

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_SCAN      = 6'b000010,
    S_SCAN_WAIT = 6'b000100,
    S_PICK      = 6'b001000,
    S_SHIFT     = 6'b010000,
    S_FINISH    = 6'b100000
  } state_e;

  typedef struct packed {
    logic valid;
    logic first;
  } scan_ctrl_t;

endpackage

// ===== sv/umpq_ram.sv =====
// Entry store: one write port, one read port, registered read data.
// Depends on umpq_pkg for the data width.
module umpq_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                              clk_i,
  input  logic                              wr_en_i,
  input  logic [AW-1:0]                     wr_addr_i,
  input  logic signed [umpq_pkg::DataW-1:0] wr_data_i,
  input  logic                              rd_en_i,
  input  logic [AW-1:0]                     rd_addr_i,
  output logic signed [umpq_pkg::DataW-1:0] rd_data_o
);

  logic signed [umpq_pkg::DataW-1:0] mem_q [DEPTH];
  logic signed [umpq_pkg::DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/umpq_maxscan.sv =====
// Running maximum over a stream of entries read from the store.
// Strict compare keeps the oldest entry on ties. Depends on umpq_pkg.
module umpq_maxscan #(
  parameter int AW = 4
) (
  input  logic                              clk_i,
  input  umpq_pkg::scan_ctrl_t              ctrl_i,
  input  logic [AW-1:0]                     idx_i,
  input  logic signed [umpq_pkg::DataW-1:0] data_i,
  output logic [AW-1:0]                     best_idx_o,
  output logic signed [umpq_pkg::DataW-1:0] best_val_o
);

  logic [AW-1:0]                     best_idx_q;
  logic signed [umpq_pkg::DataW-1:0] best_val_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid && (ctrl_i.first || (data_i > best_val_q))) begin
      best_idx_q <= idx_i;
      best_val_q <= data_i;
    end
  end

  assign best_idx_o = best_idx_q;
  assign best_val_o = best_val_q;

endmodule

// ===== sv/unordered_max_priority_queue.sv =====
// Top level of the unordered max priority queue: control, count and results.
// Depends on umpq_pkg, umpq_ram and umpq_maxscan.
//
// Use: a request is taken at a rising edge with start_i high and busy_o low.
// req_type_i selects enqueue of value_i or dequeue of the largest entry
// (oldest one on ties). Each request gives one result, shown for one cycle
// with done_o high: status_o, removed_value_o, count_o, oldest_value_o and
// newest_value_o. The receiver has no way to stall; results are not held.
// An enqueue, a full enqueue and an empty dequeue give their result in the
// cycle after the transfer and keep busy_o low. A dequeue of one of n entries
// keeps busy_o high while one pass of n reads finds the maximum and a second
// pass moves the later entries down by one, both through the single read port
// of the entry store; its result shows in the same cycle as busy_o falls.
// Reset empties the queue; entry contents are not cleared and are never read
// before being written.
module unordered_max_priority_queue #(
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              req_type_i,
  input  logic signed [umpq_pkg::DataW-1:0] value_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic signed [umpq_pkg::DataW-1:0] removed_value_o,
  output logic [CW-1:0]                     count_o,
  output logic signed [umpq_pkg::DataW-1:0] oldest_value_o,
  output logic signed [umpq_pkg::DataW-1:0] newest_value_o
);

  localparam int DW = umpq_pkg::DataW;

  umpq_pkg::state_e state_q, state_d;

  logic [CW-1:0]        cnt_q, cnt_d, ptr_q, ptr_d, cnt_m1;
  logic signed [DW-1:0] oldest_q, oldest_d, newest_q, newest_d;
  logic signed [DW-1:0] removed_q, removed_d;
  logic [1:0]           status_q, status_d;
  logic                 done_q, done_d;

  logic                 rd_en, rd_shift, rdv_q, rshift_q;
  logic [AW-1:0]        rd_addr, ridx_q;
  logic signed [DW-1:0] rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic signed [DW-1:0] wr_data;

  logic signed [DW-1:0] second_q, penult_q;
  logic [AW-1:0]        best_idx;
  logic signed [DW-1:0] best_val;
  umpq_pkg::scan_ctrl_t scan_ctrl;

  assign cnt_m1 = cnt_q - 1'b1;
  assign busy_o = (state_q != umpq_pkg::S_IDLE);

  assign scan_ctrl.valid = rdv_q && !rshift_q;
  assign scan_ctrl.first = (ridx_q == '0);

  umpq_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  umpq_maxscan #(.AW(AW)) u_scan (
    .clk_i      (clk_i),
    .ctrl_i     (scan_ctrl),
    .idx_i      (ridx_q),
    .data_i     (rd_data),
    .best_idx_o (best_idx),
    .best_val_o (best_val)
  );

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    cnt_d     = cnt_q;
    oldest_d  = oldest_q;
    newest_d  = newest_q;
    status_d  = status_q;
    removed_d = removed_q;
    done_d    = 1'b0;
    rd_en     = 1'b0;
    rd_shift  = 1'b0;
    rd_addr   = ptr_q[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = cnt_q[AW-1:0];
    wr_data   = value_i;

    case (state_q)
      umpq_pkg::S_IDLE: begin
        if (start_i) begin
          if (req_type_i == umpq_pkg::REQ_ENQ) begin
            removed_d = '0;
            done_d    = 1'b1;
            if (cnt_q == CW'(DEPTH)) begin
              status_d = umpq_pkg::ST_FULL;
            end else begin
              status_d = umpq_pkg::ST_OK;
              wr_en    = 1'b1;
              cnt_d    = cnt_q + 1'b1;
              newest_d = value_i;
              if (cnt_q == '0) begin
                oldest_d = value_i;
              end
            end
          end else if (cnt_q == '0) begin
            status_d  = umpq_pkg::ST_EMPTY;
            removed_d = '0;
            done_d    = 1'b1;
          end else begin
            ptr_d   = '0;
            state_d = umpq_pkg::S_SCAN;
          end
        end
      end
      umpq_pkg::S_SCAN: begin
        rd_en = 1'b1;
        if (ptr_q == cnt_m1) begin
          state_d = umpq_pkg::S_SCAN_WAIT;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      umpq_pkg::S_SCAN_WAIT: begin
        state_d = umpq_pkg::S_PICK;
      end
      umpq_pkg::S_PICK: begin
        ptr_d     = CW'(best_idx) + 1'b1;
        removed_d = best_val;
        state_d   = umpq_pkg::S_SHIFT;
      end
      umpq_pkg::S_SHIFT: begin
        if (ptr_q < cnt_q) begin
          rd_en    = 1'b1;
          rd_shift = 1'b1;
          ptr_d    = ptr_q + 1'b1;
        end else begin
          state_d = umpq_pkg::S_FINISH;
        end
      end
      umpq_pkg::S_FINISH: begin
        cnt_d    = cnt_m1;
        status_d = umpq_pkg::ST_OK;
        done_d   = 1'b1;
        state_d  = umpq_pkg::S_IDLE;
        if (cnt_m1 == '0) begin
          oldest_d = '0;
          newest_d = '0;
        end else begin
          if (best_idx == '0) begin
            oldest_d = second_q;
          end
          if (CW'(best_idx) == cnt_m1) begin
            newest_d = penult_q;
          end
        end
      end
      default: begin
        state_d = umpq_pkg::S_IDLE;
      end
    endcase

    // shift pass: entry i+1 read last cycle is written to entry i
    if (rdv_q && rshift_q) begin
      wr_en   = 1'b1;
      wr_addr = ridx_q - 1'b1;
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= umpq_pkg::S_IDLE;
      cnt_q    <= '0;
      ptr_q    <= '0;
      done_q   <= 1'b0;
      rdv_q    <= 1'b0;
      rshift_q <= 1'b0;
      oldest_q <= '0;
      newest_q <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ptr_q    <= ptr_d;
      done_q   <= done_d;
      rdv_q    <= rd_en;
      rshift_q <= rd_shift;
      oldest_q <= oldest_d;
      newest_q <= newest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    removed_q <= removed_d;
    ridx_q    <= rd_addr;
    if (rdv_q && !rshift_q) begin
      if (ridx_q == AW'(1)) begin
        second_q <= rd_data;
      end
      if (CW'(ridx_q) == (cnt_q - CW'(2))) begin
        penult_q <= rd_data;
      end
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign count_o         = cnt_q;
  assign oldest_value_o  = oldest_q;
  assign newest_value_o  = newest_q;

`ifndef SYNTH
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("stored count above depth");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == umpq_pkg::S_IDLE))
    else $error("result shown while a dequeue is in flight");

  a_pick_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == umpq_pkg::S_PICK) |-> !rdv_q)
    else $error("scan read still pending at pick");

  a_deq_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == umpq_pkg::S_FINISH) |=> (done_o && (cnt_q == $past(cnt_m1))))
    else $error("dequeue did not remove exactly one entry");
`endif

endmodule
